>>> hdl/tnrx_pkg.sv
// Package for the telnet receive byte filter.
// Holds the telnet and character codes, the parser state type and the queue entry type.
// No dependencies.
package tnrx_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [BYTE_W-1:0] TEL_IAC  = 8'd255;
	localparam logic [BYTE_W-1:0] TEL_DONT = 8'd254;
	localparam logic [BYTE_W-1:0] TEL_DO   = 8'd253;
	localparam logic [BYTE_W-1:0] TEL_WONT = 8'd252;
	localparam logic [BYTE_W-1:0] TEL_WILL = 8'd251;
	localparam logic [BYTE_W-1:0] TEL_SB   = 8'd250;
	localparam logic [BYTE_W-1:0] TEL_SE   = 8'd240;
	localparam logic [BYTE_W-1:0] CH_DEL   = 8'h7F;
	localparam logic [BYTE_W-1:0] CH_BS    = 8'h08;
	localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
	localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;

	typedef enum logic [2:0] {
		PS_NORMAL = 3'd0,
		PS_CMD    = 3'd1,
		PS_OPT    = 3'd2,
		PS_SUB    = 3'd3,
		PS_SUBIAC = 3'd4
	} parse_state_t;

	// One transfer from the parser into the data queue.
	typedef struct packed {
		logic              vld;
		logic [BYTE_W-1:0] data;
	} data_push_t;

endpackage

>>> hdl/telnet_rx_byte_filter.sv
// Telnet receive byte filter: IAC stripping followed by line-ending normalization.
// An output byte is written into the data queue at its input transfer, then moved to the
// output register. Throughput: one byte per cycle while out_ready is high, set by the
// parser and output register.
// Reset (arst_n low) clears the parser state, the queue and the CR flag, as for a new
// connection; no clearing pass is needed.
module telnet_rx_byte_filter
	import tnrx_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [BYTE_W-1:0] in_byte,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [BYTE_W-1:0] out_byte
);

	data_push_t        push;
	logic              queue_full, queue_empty, pop;
	logic [BYTE_W-1:0] queue_data;

	tnrx_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.queue_full (queue_full),
		.push       (push)
	);

	tnrx_fifo #(
		.DEPTH (QUEUE_DEPTH_P)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (queue_full),
		.pop     (pop),
		.empty   (queue_empty),
		.rd_data (queue_data)
	);

	tnrx_norm u_norm (
		.clk         (clk),
		.arst_n      (arst_n),
		.queue_empty (queue_empty),
		.queue_data  (queue_data),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte)
	);

endmodule

>>> hdl/tnrx_parse.sv
// Front end of the telnet receive filter: strips IAC command sequences.
// Data bytes (including the literal 255 of IAC IAC) are pushed into the queue.
// Depends on tnrx_pkg.
module tnrx_parse
	import tnrx_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [BYTE_W-1:0] in_byte,
	input  logic              queue_full,
	output data_push_t        push
);

	parse_state_t state_q, state_d;
	logic         accept;
	logic         is_data;

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PS_NORMAL;
		end else if (accept) begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = PS_NORMAL;
		is_data = 1'b0;
		case (state_q)
			PS_CMD: begin
				if (in_byte == TEL_IAC) begin
					is_data = 1'b1;
				end else if (in_byte inside {TEL_WILL, TEL_WONT, TEL_DO, TEL_DONT}) begin
					state_d = PS_OPT;
				end else if (in_byte == TEL_SB) begin
					state_d = PS_SUB;
				end
			end
			PS_OPT: begin
				state_d = PS_NORMAL;
			end
			PS_SUB: begin
				state_d = (in_byte == TEL_IAC) ? PS_SUBIAC : PS_SUB;
			end
			PS_SUBIAC: begin
				state_d = (in_byte == TEL_SE) ? PS_NORMAL : PS_SUB;
			end
			default: begin
				if (in_byte == TEL_IAC) begin
					state_d = PS_CMD;
				end else begin
					is_data = 1'b1;
				end
			end
		endcase
	end

	assign push.vld  = accept && is_data;
	assign push.data = in_byte;

endmodule

>>> hdl/tnrx_fifo.sv
// Short data queue between the parser and the line-ending stage.
// Circular buffer with read and write pointers and a fill count.
// Depends on tnrx_pkg.
module tnrx_fifo
	import tnrx_pkg::*;
#(
	parameter int unsigned DEPTH = QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  data_push_t        push,
	output logic              full,
	input  logic              pop,
	output logic              empty,
	output logic [BYTE_W-1:0] rd_data
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	logic [BYTE_W-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push, do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push.vld && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> hdl/tnrx_norm.sv
// Back end of the telnet receive filter: line-ending normalization of data bytes.
// Drops LF after CR, maps a lone LF to CR, drops NUL and maps DEL to backspace.
// Depends on tnrx_pkg.
module tnrx_norm
	import tnrx_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              queue_empty,
	input  logic [BYTE_W-1:0] queue_data,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [BYTE_W-1:0] out_byte
);

	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              last_cr_q, last_cr_d;
	logic              emit;
	logic [BYTE_W-1:0] emit_byte;

	// A byte leaves the queue whenever the output register is free or being drained.
	assign pop = !queue_empty && (!out_valid_q || out_ready);

	always_comb begin
		emit      = 1'b1;
		emit_byte = queue_data;
		last_cr_d = 1'b0;
		if (queue_data == CH_CR) begin
			last_cr_d = 1'b1;
		end else if (queue_data == CH_LF) begin
			emit      = !last_cr_q;
			emit_byte = CH_CR;
		end else if (queue_data == CH_NUL) begin
			emit = 1'b0;
		end else if (queue_data == CH_DEL) begin
			emit_byte = CH_BS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			last_cr_q   <= 1'b0;
		end else if (pop) begin
			out_valid_q <= emit;
			last_cr_q   <= last_cr_d;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			out_byte_q <= emit_byte;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;

endmodule
